[rtl/tis_pkg.sv]
// ----------------------------------------------------------------------------
// tis_pkg
// Shared types and constants for the triangle isoline segment block.
// ----------------------------------------------------------------------------
package tis_pkg;

	// Address bits of the queue between the front and back parts
	localparam int QUEUE_AW = 2;

	// Which corner is the odd one out
	typedef enum logic [1:0] {
		CORNER_NONE,
		CORNER_A,
		CORNER_B,
		CORNER_C
	} corner_t;

endpackage

[rtl/tis_front.sv]
// ----------------------------------------------------------------------------
// tis_front
// Accepts triangles, finds the odd corner, rotates the corners and forms the
// edge deltas and sign-normalized ratios. Triangles with no crossing are
// dropped here.
// ----------------------------------------------------------------------------
module tis_front #(
	parameter int COORD_BITS  = 32,
	parameter int SCALAR_BITS = 16,
	parameter int ITEM_W      = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_BITS-1:0]  a_x,
	input  logic signed [COORD_BITS-1:0]  a_y,
	input  logic signed [COORD_BITS-1:0]  a_z,
	input  logic signed [COORD_BITS-1:0]  b_x,
	input  logic signed [COORD_BITS-1:0]  b_y,
	input  logic signed [COORD_BITS-1:0]  b_z,
	input  logic signed [COORD_BITS-1:0]  c_x,
	input  logic signed [COORD_BITS-1:0]  c_y,
	input  logic signed [COORD_BITS-1:0]  c_z,
	input  logic signed [SCALAR_BITS-1:0] val_a,
	input  logic signed [SCALAR_BITS-1:0] val_b,
	input  logic signed [SCALAR_BITS-1:0] val_c,
	output logic                          push,
	input  logic                          full,
	output logic [ITEM_W-1:0]             item
);
	import tis_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int SB = SCALAR_BITS;

	corner_t sel;
	logic na, nb, nc, pa, pb, pc;
	logic signed [CB-1:0] px, py, pz, qx, qy, qz, rx, ry, rz;
	logic signed [SB-1:0] sp, sq, sr;
	logic signed [SB:0]   den1, den2, s1, s2;
	logic        [SB-1:0] m1, m2;
	logic signed [CB:0]   d1x, d1y, d1z, d2x, d2y, d2z;
	logic [ITEM_W-1:0]    item_d;

	logic              valid_s1;
	logic [ITEM_W-1:0] item_s1;

	always_comb begin
		na = val_a[SB-1];
		nb = val_b[SB-1];
		nc = val_c[SB-1];
		pa = !na && (val_a != '0);
		pb = !nb && (val_b != '0);
		pc = !nc && (val_c != '0);
		if ((na && !nb && !nc) || (pa && !pb && !pc)) begin
			sel = CORNER_A;
		end else if ((nb && !nc && !na) || (pb && !pc && !pa)) begin
			sel = CORNER_B;
		end else if ((nc && !na && !nb) || (pc && !pa && !pb)) begin
			sel = CORNER_C;
		end else begin
			sel = CORNER_NONE;
		end
	end

	always_comb begin
		case (sel)
			CORNER_B: begin
				px = b_x; py = b_y; pz = b_z; sp = val_b;
				qx = c_x; qy = c_y; qz = c_z; sq = val_c;
				rx = a_x; ry = a_y; rz = a_z; sr = val_a;
			end
			CORNER_C: begin
				px = c_x; py = c_y; pz = c_z; sp = val_c;
				qx = a_x; qy = a_y; qz = a_z; sq = val_a;
				rx = b_x; ry = b_y; rz = b_z; sr = val_b;
			end
			default: begin
				px = a_x; py = a_y; pz = a_z; sp = val_a;
				qx = b_x; qy = b_y; qz = b_z; sq = val_b;
				rx = c_x; ry = c_y; rz = c_z; sr = val_c;
			end
		endcase
	end

	always_comb begin
		den1 = {sp[SB-1], sp} - {sq[SB-1], sq};
		den2 = {sp[SB-1], sp} - {sr[SB-1], sr};
		// fold the denominator sign into the numerator
		if (den1[SB]) begin
			m1 = SB'(-den1);
			s1 = -{sp[SB-1], sp};
		end else begin
			m1 = SB'(den1);
			s1 = {sp[SB-1], sp};
		end
		if (den2[SB]) begin
			m2 = SB'(-den2);
			s2 = -{sp[SB-1], sp};
		end else begin
			m2 = SB'(den2);
			s2 = {sp[SB-1], sp};
		end
		d1x = {qx[CB-1], qx} - {px[CB-1], px};
		d1y = {qy[CB-1], qy} - {py[CB-1], py};
		d1z = {qz[CB-1], qz} - {pz[CB-1], pz};
		d2x = {rx[CB-1], rx} - {px[CB-1], px};
		d2y = {ry[CB-1], ry} - {py[CB-1], py};
		d2z = {rz[CB-1], rz} - {pz[CB-1], pz};
		item_d = {px, py, pz, d1x, d1y, d1z, d2x, d2y, d2z, s1, s2, m1, m2};
	end

	assign in_stall = valid_s1 && full;
	assign push     = valid_s1 && !full;
	assign item     = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid && (sel != CORNER_NONE);
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= item_d;
		end
	end

endmodule

[rtl/tis_queue.sv]
// ----------------------------------------------------------------------------
// tis_queue
// Short queue between the front and back parts.
// ----------------------------------------------------------------------------
module tis_queue #(
	parameter int ITEM_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [ITEM_W-1:0] wdata,
	output logic              full,
	input  logic              pop,
	output logic              empty,
	output logic [ITEM_W-1:0] head
);
	import tis_pkg::*;

	localparam int DEPTH = 1 << QUEUE_AW;

	logic [ITEM_W-1:0]   mem_q [0:DEPTH-1];
	logic [QUEUE_AW-1:0] wp_q, rp_q;
	logic [QUEUE_AW:0]   cnt_q;

	assign full  = (cnt_q == (QUEUE_AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("queue read while empty");
	a_count_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count lost a transfer");
`endif

endmodule

[rtl/tis_lane.sv]
// ----------------------------------------------------------------------------
// tis_lane
// One coordinate: p0 + round(d * s / dm), ties away from zero, saturated.
// Multiply, then a restoring divider resolving one quotient bit per stage.
// ----------------------------------------------------------------------------
module tis_lane #(
	parameter int COORD_BITS  = 32,
	parameter int SCALAR_BITS = 16
) (
	input  logic                          clk,
	input  logic                          adv,
	input  logic signed [COORD_BITS-1:0]  p0,
	input  logic signed [COORD_BITS:0]    d,
	input  logic signed [SCALAR_BITS:0]   s,
	input  logic        [SCALAR_BITS-1:0] dm,
	output logic signed [COORD_BITS-1:0]  res
);
	localparam int CB = COORD_BITS;
	localparam int SB = SCALAR_BITS;
	localparam int PW = CB + SB + 2;
	localparam int NW = PW + 1;
	localparam int QW = CB + 1;

	logic signed [PW-1:0] num_s1;
	logic signed [CB-1:0] p0_s1;
	logic        [SB-1:0] dm_s1;

	logic        [PW-1:0] mag;
	logic        [NW-1:0] nsum;

	logic        [SB:0]   div_rem_s [0:QW];
	logic        [QW-1:0] div_low_s [0:QW];
	logic        [QW-1:0] div_q_s   [0:QW];
	logic        [SB-1:0] div_dm_s  [0:QW];
	logic                 div_neg_s [0:QW];
	logic signed [CB-1:0] div_p0_s  [0:QW];

	logic signed [CB+1:0] sum;
	logic signed [CB-1:0] sat;
	logic signed [CB-1:0] res_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s1 <= PW'(d) * PW'(s);
			p0_s1  <= p0;
			dm_s1  <= dm;
		end
	end

	always_comb begin
		mag  = num_s1[PW-1] ? PW'(-num_s1) : PW'(num_s1);
		nsum = {mag, 1'b0} + NW'(dm_s1);
	end

	// quotient fits QW bits, so the bits above QW are already below 2*dm
	always_ff @(posedge clk) begin
		if (adv) begin
			div_rem_s[0] <= nsum[QW+SB:QW];
			div_low_s[0] <= nsum[QW-1:0];
			div_q_s[0]   <= '0;
			div_dm_s[0]  <= dm_s1;
			div_neg_s[0] <= num_s1[PW-1];
			div_p0_s[0]  <= p0_s1;
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_div
		logic [SB+1:0] trial;
		logic [SB+1:0] dv;
		logic          ge;

		always_comb begin
			trial = {div_rem_s[k], div_low_s[k][QW-1]};
			dv    = {1'b0, div_dm_s[k], 1'b0};
			ge    = (trial >= dv);
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_rem_s[k+1] <= ge ? (SB+1)'(trial - dv) : (SB+1)'(trial);
				div_low_s[k+1] <= {div_low_s[k][QW-2:0], 1'b0};
				div_q_s[k+1]   <= {div_q_s[k][QW-2:0], ge};
				div_dm_s[k+1]  <= div_dm_s[k];
				div_neg_s[k+1] <= div_neg_s[k];
				div_p0_s[k+1]  <= div_p0_s[k];
			end
		end
	end

	always_comb begin
		if (div_neg_s[QW]) begin
			sum = (CB+2)'(div_p0_s[QW]) - (CB+2)'({1'b0, div_q_s[QW]});
		end else begin
			sum = (CB+2)'(div_p0_s[QW]) + (CB+2)'({1'b0, div_q_s[QW]});
		end
		if (sum > $signed((CB+2)'({2'b00, 1'b0, {(CB-1){1'b1}}}))) begin
			sat = {1'b0, {(CB-1){1'b1}}};
		end else if (sum < -$signed((CB+2)'({2'b00, 1'b1, {(CB-1){1'b0}}}))) begin
			sat = {1'b1, {(CB-1){1'b0}}};
		end else begin
			sat = CB'(sum);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= sat;
		end
	end

	assign res = res_q;

endmodule

[rtl/tis_back.sv]
// ----------------------------------------------------------------------------
// tis_back
// Six interpolation lanes under one valid pipeline; the last lane stage is
// the output register. The whole pipeline holds while valid output stalls.
// ----------------------------------------------------------------------------
module tis_back #(
	parameter int COORD_BITS  = 32,
	parameter int SCALAR_BITS = 16,
	parameter int ITEM_W      = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         empty,
	input  logic [ITEM_W-1:0]            head,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [COORD_BITS-1:0] start_x,
	output logic signed [COORD_BITS-1:0] start_y,
	output logic signed [COORD_BITS-1:0] start_z,
	output logic signed [COORD_BITS-1:0] end_x,
	output logic signed [COORD_BITS-1:0] end_y,
	output logic signed [COORD_BITS-1:0] end_z
);
	localparam int CB  = COORD_BITS;
	localparam int SB  = SCALAR_BITS;
	localparam int LAT = CB + 4;

	logic signed [CB-1:0] px, py, pz;
	logic signed [CB:0]   d1x, d1y, d1z, d2x, d2y, d2z;
	logic signed [SB:0]   s1, s2;
	logic        [SB-1:0] m1, m2;

	logic [LAT-1:0] vld_q;
	logic           adv;

	assign {px, py, pz, d1x, d1y, d1z, d2x, d2y, d2z, s1, s2, m1, m2} = head;

	assign adv       = !(vld_q[LAT-1] && out_stall);
	assign pop       = adv && !empty;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], !empty};
		end
	end

	tis_lane #(.COORD_BITS(CB), .SCALAR_BITS(SB)) u_sx (
		.clk(clk), .adv(adv), .p0(px), .d(d1x), .s(s1), .dm(m1), .res(start_x));
	tis_lane #(.COORD_BITS(CB), .SCALAR_BITS(SB)) u_sy (
		.clk(clk), .adv(adv), .p0(py), .d(d1y), .s(s1), .dm(m1), .res(start_y));
	tis_lane #(.COORD_BITS(CB), .SCALAR_BITS(SB)) u_sz (
		.clk(clk), .adv(adv), .p0(pz), .d(d1z), .s(s1), .dm(m1), .res(start_z));
	tis_lane #(.COORD_BITS(CB), .SCALAR_BITS(SB)) u_ex (
		.clk(clk), .adv(adv), .p0(px), .d(d2x), .s(s2), .dm(m2), .res(end_x));
	tis_lane #(.COORD_BITS(CB), .SCALAR_BITS(SB)) u_ey (
		.clk(clk), .adv(adv), .p0(py), .d(d2y), .s(s2), .dm(m2), .res(end_y));
	tis_lane #(.COORD_BITS(CB), .SCALAR_BITS(SB)) u_ez (
		.clk(clk), .adv(adv), .p0(pz), .d(d2z), .s(s2), .dm(m2), .res(end_z));

endmodule

[rtl/triangle_isoline_segment.sv]
// ----------------------------------------------------------------------------
// triangle_isoline_segment
// Marching-triangles isoline segment: one triangle in, zero or one segment out.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with three corners (Q16.16) and three
// scalars (Q1.15). A triangle transfers when in_valid is high and in_stall low.
// Output channel: out_valid / out_stall with the segment start and end points.
// Triangles without a crossing produce no output transfer.
// Throughput: one triangle per cycle while in_stall is low. From input transfer
// to out_valid a triangle passes the front register, the queue, a multiply
// stage, a divider setup stage, COORD_BITS+1 divider stages, and the output
// register; the divider resolves one quotient bit per stage.
// When out_stall holds a valid result, the back pipeline freezes; the
// four-entry queue absorbs the front's output, and in_stall rises once it
// fills. Reset clears all valid bits and the queue; no output is pending.
// ----------------------------------------------------------------------------
module triangle_isoline_segment #(
	parameter int COORD_BITS  = 32,
	parameter int SCALAR_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_BITS-1:0]  a_x,
	input  logic signed [COORD_BITS-1:0]  a_y,
	input  logic signed [COORD_BITS-1:0]  a_z,
	input  logic signed [COORD_BITS-1:0]  b_x,
	input  logic signed [COORD_BITS-1:0]  b_y,
	input  logic signed [COORD_BITS-1:0]  b_z,
	input  logic signed [COORD_BITS-1:0]  c_x,
	input  logic signed [COORD_BITS-1:0]  c_y,
	input  logic signed [COORD_BITS-1:0]  c_z,
	input  logic signed [SCALAR_BITS-1:0] val_a,
	input  logic signed [SCALAR_BITS-1:0] val_b,
	input  logic signed [SCALAR_BITS-1:0] val_c,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [COORD_BITS-1:0]  start_x,
	output logic signed [COORD_BITS-1:0]  start_y,
	output logic signed [COORD_BITS-1:0]  start_z,
	output logic signed [COORD_BITS-1:0]  end_x,
	output logic signed [COORD_BITS-1:0]  end_y,
	output logic signed [COORD_BITS-1:0]  end_z
);
	localparam int ITEM_W = 3 * COORD_BITS + 6 * (COORD_BITS + 1)
		+ 2 * (SCALAR_BITS + 1) + 2 * SCALAR_BITS;

	logic              push, full, pop, empty;
	logic [ITEM_W-1:0] item, head;

	tis_front #(
		.COORD_BITS(COORD_BITS), .SCALAR_BITS(SCALAR_BITS), .ITEM_W(ITEM_W)
	) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.a_x(a_x), .a_y(a_y), .a_z(a_z),
		.b_x(b_x), .b_y(b_y), .b_z(b_z),
		.c_x(c_x), .c_y(c_y), .c_z(c_z),
		.val_a(val_a), .val_b(val_b), .val_c(val_c),
		.push(push), .full(full), .item(item)
	);

	tis_queue #(.ITEM_W(ITEM_W)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(item), .full(full),
		.pop(pop), .empty(empty), .head(head)
	);

	tis_back #(
		.COORD_BITS(COORD_BITS), .SCALAR_BITS(SCALAR_BITS), .ITEM_W(ITEM_W)
	) u_back (
		.clk(clk), .arst_n(arst_n), .empty(empty), .head(head), .pop(pop),
		.out_valid(out_valid), .out_stall(out_stall),
		.start_x(start_x), .start_y(start_y), .start_z(start_z),
		.end_x(end_x), .end_y(end_y), .end_z(end_z)
	);

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for triangle_isoline_segment: random and directed
// triangles go in through a queue-fed driver; a monitor predicts each
// isoline segment and compares it with the block's output transfers.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import tis_pkg::*;

	localparam int CB = 32;
	localparam int SB = 16;
	localparam int IDLE_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic [2:0][2:0][CB-1:0] pos;   // [corner][axis]
		logic [2:0][SB-1:0]      sc;
	} triangle_t;

	typedef struct packed {
		logic [1:0][2:0][CB-1:0] pt;    // [0]=start, [1]=end
	} segment_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [CB-1:0] a_x = '0, a_y = '0, a_z = '0;
	logic signed [CB-1:0] b_x = '0, b_y = '0, b_z = '0;
	logic signed [CB-1:0] c_x = '0, c_y = '0, c_z = '0;
	logic signed [SB-1:0] val_a = '0, val_b = '0, val_c = '0;
	logic signed [CB-1:0] start_x, start_y, start_z, end_x, end_y, end_z;

	triangle_t pending_tris[$];
	segment_t  expected_segs[$];
	triangle_t cur_tri = '0;
	bit        in_fire = 0;
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;
	int        hold_req = 0;
	int        hold_seen = 0;
	int        hold_cnt = 0;
	int        mismatches = 0;
	int        idle_cycles = 0;

	always #4 clk = ~clk;

	triangle_isoline_segment u_top (.*);

	function automatic longint clamp_coord(longint v);
		longint hi, lo;
		hi = (longint'(1) <<< (CB - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	// p0 + round(d*s/den), ties away from zero
	function automatic longint zero_point(longint p0, longint p1, longint s, longint den);
		longint d, num;
		longint unsigned mag, q;
		bit neg;
		d = p1 - p0;
		if (den < 0) begin
			den = -den;
			s = -s;
		end
		num = d * s;
		neg = num < 0;
		mag = neg ? longint'(-num) : longint'(num);
		q = (2 * mag + longint'(den)) / (2 * longint'(den));
		return neg ? p0 - longint'(q) : p0 + longint'(q);
	endfunction

	function automatic bit is_odd(longint s, longint t1, longint t2);
		return (s < 0 && t1 >= 0 && t2 >= 0) || (s > 0 && t1 <= 0 && t2 <= 0);
	endfunction

	function automatic bit predict_segment(triangle_t t, output segment_t seg);
		longint sv[3];
		corner_t odd;
		int p, q, r;
		seg = '0;
		for (int i = 0; i < 3; i++) sv[i] = longint'($signed(t.sc[i]));
		odd = CORNER_NONE;
		if (is_odd(sv[0], sv[1], sv[2])) odd = CORNER_A;
		else if (is_odd(sv[1], sv[2], sv[0])) odd = CORNER_B;
		else if (is_odd(sv[2], sv[0], sv[1])) odd = CORNER_C;
		case (odd)
			CORNER_A: p = 0;
			CORNER_B: p = 1;
			CORNER_C: p = 2;
			default: return 0;
		endcase
		q = (p + 1) % 3;
		r = (p + 2) % 3;
		for (int k = 0; k < 3; k++) begin
			seg.pt[0][k] = CB'(clamp_coord(zero_point($signed(t.pos[p][k]),
				$signed(t.pos[q][k]), sv[p], sv[p] - sv[q])));
			seg.pt[1][k] = CB'(clamp_coord(zero_point($signed(t.pos[p][k]),
				$signed(t.pos[r][k]), sv[p], sv[p] - sv[r])));
		end
		return 1;
	endfunction

	function automatic logic [CB-1:0] rand_coord();
		case ($urandom_range(9))
			0: return {1'b1, {(CB-1){1'b0}}};
			1: return {1'b0, {(CB-1){1'b1}}};
			2: return CB'($urandom_range(255)) - CB'(128);
			default: return CB'($urandom);
		endcase
	endfunction

	function automatic triangle_t rand_triangle();
		triangle_t t;
		int k, sgn, kind;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) t.pos[i][j] = rand_coord();
		kind = $urandom_range(99);
		if (kind < 80) begin
			// well-formed crossing: one corner strictly opposite the others
			k = $urandom_range(2);
			sgn = $urandom_range(1);
			for (int i = 0; i < 3; i++) begin
				if (i == k) begin
					t.sc[i] = sgn ? SB'($urandom_range(32767, 1))
						: SB'(-$urandom_range(32768, 1));
				end else if ($urandom_range(3) == 0) begin
					t.sc[i] = '0;
				end else begin
					t.sc[i] = sgn ? SB'(-$urandom_range(32768, 1))
						: SB'($urandom_range(32767, 1));
				end
			end
		end else if (kind < 85) begin
			t.sc = '0;
		end else begin
			for (int i = 0; i < 3; i++) t.sc[i] = SB'($urandom);
		end
		return t;
	endfunction

	function automatic triangle_t mk_tri(int sa, int sb, int sc_v, logic [CB-1:0] ca,
		logic [CB-1:0] cb_v, logic [CB-1:0] cc);
		triangle_t t;
		t.sc[0] = SB'(sa);
		t.sc[1] = SB'(sb);
		t.sc[2] = SB'(sc_v);
		for (int j = 0; j < 3; j++) begin
			t.pos[0][j] = ca + CB'(j);
			t.pos[1][j] = cb_v - CB'(j);
			t.pos[2][j] = cc ^ CB'(j);
		end
		return t;
	endfunction

	// monitor: input transfers feed the predictor, output transfers are checked
	always @(posedge clk) begin
		segment_t seg, exp_seg, got;
		in_fire = in_valid && !in_stall;
		if (in_fire) begin
			if (predict_segment(cur_tri, seg)) expected_segs.push_back(seg);
		end
		if (out_valid && !out_stall) begin
			got.pt[0] = {start_z, start_y, start_x};
			got.pt[1] = {end_z, end_y, end_x};
			if (expected_segs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected segment transfer %h", got);
			end else begin
				exp_seg = expected_segs.pop_front();
				for (int e = 0; e < 2; e++)
					for (int k = 0; k < 3; k++)
						if (got.pt[e][k] !== exp_seg.pt[e][k]) begin
							mismatches++;
							if (mismatches <= 10)
								$display("mismatch point %0d axis %0d: expected %h got %h",
									e, k, exp_seg.pt[e][k], got.pt[e][k]);
						end
			end
		end
		if (in_fire || (out_valid && !out_stall)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	// driver
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_fire)) begin
			if (pending_tris.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				triangle_t t;
				t = pending_tris.pop_front();
				cur_tri <= t;
				{a_z, a_y, a_x} <= t.pos[0];
				{b_z, b_y, b_x} <= t.pos[1];
				{c_z, c_y, c_x} <= t.pos[2];
				{val_c, val_b, val_a} <= t.sc;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall, with a long hold-off on request
	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_cnt = HOLD_CYCLES;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	task automatic wait_drained();
		while (pending_tris.size() > 0 || in_valid || expected_segs.size() > 0 || hold_cnt > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	initial begin
		int sends[4] = '{0, 71, 0, 20};
		int recvs[4] = '{0, 0, 71, 20};
		logic [CB-1:0] mx, mn;
		mx = {1'b0, {(CB-1){1'b1}}};
		mn = {1'b1, {(CB-1){1'b0}}};
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed: each odd corner, extremes, zeros, ties, no crossing
		pending_tris.push_back(mk_tri(100, -100, -50, 0, 32'h10000, 32'h20000));
		pending_tris.push_back(mk_tri(-100, 100, -50, 0, 32'h10000, 32'h20000));
		pending_tris.push_back(mk_tri(-100, -50, 100, 0, 32'h10000, 32'h20000));
		pending_tris.push_back(mk_tri(-32768, 32767, 32767, mn, mx, mx));
		pending_tris.push_back(mk_tri(32767, -32768, -32768, mx, mn, mn));
		pending_tris.push_back(mk_tri(-32768, 0, 0, mx, mn, mx));
		pending_tris.push_back(mk_tri(1, 0, 0, mn, mx, mn));
		pending_tris.push_back(mk_tri(1, -1, -1, 0, 1, 3));
		pending_tris.push_back(mk_tri(-1, 1, 1, 0, -1, -3));
		pending_tris.push_back(mk_tri(0, 0, 0, 0, 1, 2));
		pending_tris.push_back(mk_tri(5, 6, 7, 0, 1, 2));
		pending_tris.push_back(mk_tri(-5, -6, -7, 0, 1, 2));
		pending_tris.push_back(mk_tri(0, 5, -5, mn, mx, 0));
		pending_tris.push_back(mk_tri(5, 0, -5, mx, mn, 0));
		pending_tris.push_back(mk_tri(32767, -1, 0, mx, mn, 7));
		pending_tris.push_back(mk_tri(-1, 32767, -32768, 3, 5, 9));
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = sends[ph];
			recv_stall_pct = recvs[ph];
			if (ph == 0) hold_req++;
			for (int i = 0; i < 130; i++) pending_tris.push_back(rand_triangle());
			// sender pause until every segment is out
			while (pending_tris.size() > 0 || in_valid || expected_segs.size() > 0)
				@(posedge clk);
			for (int i = 0; i < 130; i++) pending_tris.push_back(rand_triangle());
			wait_drained();
		end

		repeat (100) @(posedge clk);
		if (mismatches == 0 && expected_segs.size() == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end
endmodule
